FILE: rtl/whds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whds_pkg
// Shared types and constants of the WAV header duration scanner.
// ----------------------------------------------------------------------------
package whds_pkg;

	// header field offsets (byte position in the file)
	localparam logic [5:0] POS_CHANNELS = 6'd22;
	localparam logic [5:0] POS_RATE     = 6'd24;
	localparam logic [5:0] POS_BITS     = 6'd34;
	localparam logic [5:0] POS_LIMIT    = 6'd36;

	// "dat" in the window, then 'a'
	localparam logic [23:0] TAG_HEAD = 24'h646174;
	localparam logic [7:0]  TAG_LAST = 8'h61;

	localparam logic [9:0] MS_PER_SECOND = 10'd1000;

	localparam int RATE_W = 32;
	localparam int CHAN_W = 16;
	localparam int BITS_W = 16;
	localparam int SIZE_W = 32;
	localparam int BPB_W  = BITS_W - 3;           // bits / 8
	localparam int PROD_W = RATE_W + CHAN_W;      // rate * channels
	localparam int DIV_W  = PROD_W + BPB_W;       // bytes per second
	localparam int NUM_W  = SIZE_W + 10;          // size * 1000
	localparam int DUR_W  = 32;
	localparam int ODATA_W = 40;                  // 35 payload bits, byte padded

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_DATA = 2'd1;
	localparam logic [1:0] STATUS_ZERO_BPS = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [RATE_W-1:0] rate;
		logic [CHAN_W-1:0] chan;
		logic [BITS_W-1:0] bits;
		logic              complete;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/whds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whds_front
// Byte parser: captures header fields by position, finds the "data" tag and
// its size, and pushes one job per file on the final byte.
// ----------------------------------------------------------------------------
module whds_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] file_byte
	input  logic                 s_tlast,   // final_byte
	input  whds_pkg::q_stat_t    q_stat,
	output logic                 push,
	output whds_pkg::job_t       push_job
);

	logic [5:0]                   pos_q;
	logic [whds_pkg::RATE_W-1:0]  rate_q, rate_n;
	logic [whds_pkg::CHAN_W-1:0]  chan_q, chan_n;
	logic [whds_pkg::BITS_W-1:0]  bits_q, bits_n;
	logic [23:0]                  window_q;
	logic                         tag_q;
	logic [2:0]                   taken_q;
	logic [whds_pkg::SIZE_W-1:0]  size_q, size_n;
	logic                         accept;
	logic [7:0]                   b;

	assign b        = s_tdata;
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && s_tlast;

	// header capture, also applied on the final byte
	always_comb begin
		rate_n = rate_q;
		chan_n = chan_q;
		bits_n = bits_q;
		case (pos_q)
			whds_pkg::POS_CHANNELS:        chan_n[7:0]   = b;
			whds_pkg::POS_CHANNELS + 6'd1: chan_n[15:8]  = b;
			whds_pkg::POS_RATE:            rate_n[7:0]   = b;
			whds_pkg::POS_RATE + 6'd1:     rate_n[15:8]  = b;
			whds_pkg::POS_RATE + 6'd2:     rate_n[23:16] = b;
			whds_pkg::POS_RATE + 6'd3:     rate_n[31:24] = b;
			whds_pkg::POS_BITS:            bits_n[7:0]   = b;
			whds_pkg::POS_BITS + 6'd1:     bits_n[15:8]  = b;
			default: ;
		endcase
	end

	always_comb begin
		size_n = size_q;
		case (taken_q[1:0])
			2'd0:    size_n[7:0]   = b;
			2'd1:    size_n[15:8]  = b;
			2'd2:    size_n[23:16] = b;
			default: size_n[31:24] = b;
		endcase
	end

	always_comb begin
		push_job.size     = size_q;
		push_job.rate     = rate_n;
		push_job.chan     = chan_n;
		push_job.bits     = bits_n;
		push_job.complete = tag_q && taken_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			rate_q   <= '0;
			chan_q   <= '0;
			bits_q   <= '0;
			window_q <= '0;
			tag_q    <= 1'b0;
			taken_q  <= '0;
			size_q   <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				// file done: back to the reset state for the next one
				pos_q    <= '0;
				rate_q   <= '0;
				chan_q   <= '0;
				bits_q   <= '0;
				window_q <= '0;
				tag_q    <= 1'b0;
				taken_q  <= '0;
				size_q   <= '0;
			end else begin
				if (pos_q < whds_pkg::POS_LIMIT) begin
					pos_q <= pos_q + 6'd1;
				end
				rate_q <= rate_n;
				chan_q <= chan_n;
				bits_q <= bits_n;
				if (!tag_q) begin
					if (window_q == whds_pkg::TAG_HEAD && b == whds_pkg::TAG_LAST) begin
						tag_q <= 1'b1;
					end
				end else if (!taken_q[2]) begin
					size_q  <= size_n;
					taken_q <= taken_q + 3'd1;
				end
				window_q <= {window_q[15:0], b};
			end
		end
	end

endmodule

FILE: rtl/whds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whds_queue
// Small job queue between the byte parser and the arithmetic back end.
// ----------------------------------------------------------------------------
module whds_queue #(
	parameter int DEPTH = whds_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  whds_pkg::job_t    push_job,
	input  logic              pop,
	output whds_pkg::job_t    pop_job,
	output whds_pkg::q_stat_t q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	whds_pkg::job_t mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_job      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/whds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whds_back
// Duration arithmetic: two registered multiplies for the byte rate, one for
// size * 1000, a bit-serial restoring divide, saturation and the output
// register.
// ----------------------------------------------------------------------------
module whds_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  whds_pkg::q_stat_t             q_stat,
	input  whds_pkg::job_t                pop_job,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [whds_pkg::ODATA_W-1:0]  m_tdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam int DW = whds_pkg::DIV_W;
	localparam int NW = whds_pkg::NUM_W;
	localparam int PW = whds_pkg::PROD_W;

	logic [2:0]                   state_q;
	whds_pkg::job_t               job_q;
	logic [whds_pkg::PROD_W-1:0]  prod_q;
	logic [DW-1:0]                div_q;
	logic [DW-1:0]                rem_q;
	logic [NW-1:0]                quo_q;
	logic [5:0]                   cnt_q;
	logic [1:0]                   status_q;
	logic                         m_tvalid_q;
	logic [whds_pkg::ODATA_W-1:0] m_tdata_q;
	logic [DW:0]                  rem_shift;
	logic [DW:0]                  rem_diff;
	logic                         sub_ok;
	logic                         out_free;
	logic                         clip;
	logic [whds_pkg::DUR_W-1:0]   dur;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	assign rem_shift = {rem_q, quo_q[NW-1]};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign sub_ok    = (rem_shift >= {1'b0, div_q});

	assign clip = |quo_q[NW-1:whds_pkg::DUR_W];
	assign dur  = clip ? '1 : quo_q[whds_pkg::DUR_W-1:0];

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= pop_job;
			end
			ST_MUL1: begin
				prod_q <= PW'(job_q.rate) * PW'(job_q.chan);
			end
			ST_MUL2: begin
				div_q <= DW'(prod_q) * DW'(job_q.bits[whds_pkg::BITS_W-1:3]);
				quo_q <= NW'(job_q.size) * NW'(whds_pkg::MS_PER_SECOND);
				rem_q <= '0;
			end
			ST_DIV: begin
				// one quotient bit per cycle, MSB first
				if (sub_ok) begin
					rem_q <= rem_diff[DW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[DW-1:0];
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			status_q   <= whds_pkg::STATUS_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						if (pop_job.complete) begin
							status_q <= whds_pkg::STATUS_OK;
							state_q  <= ST_MUL1;
						end else begin
							status_q <= whds_pkg::STATUS_NO_DATA;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_CHK;
				ST_CHK: begin
					cnt_q <= '0;
					if (div_q == '0) begin
						status_q <= whds_pkg::STATUS_ZERO_BPS;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(NW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (status_q == whds_pkg::STATUS_OK) begin
							m_tdata_q <= whds_pkg::ODATA_W'({clip, status_q, dur});
						end else begin
							m_tdata_q <= whds_pkg::ODATA_W'({1'b0, status_q,
								{whds_pkg::DUR_W{1'b0}}});
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/wav_header_duration_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_duration_scanner_core
// Scans a WAV byte stream and reports its playback duration in ms.
// ----------------------------------------------------------------------------
// Input channel s_*: one file byte per item in s_tdata[7:0], s_tlast marks
// the last byte of a file. Bytes are taken at one per cycle; s_tready drops
// only while the job queue is full.
// Output channel m_*: one result item per file, m_tdata[31:0] duration_ms,
// [33:32] status (ok, no data chunk, zero bytes per second), [34] clipped.
// When the divide runs, a result follows the final byte through pop, the two
// multiply states, the zero check, 42 divide steps and the output load; a
// job without a data chunk skips to the output load, and a zero byte rate
// skips the divide. The divider is bit-serial with 42 steps; one file is
// worked on at a time, while the front keeps parsing the next file and up
// to QUEUE_DEPTH finished headers wait in the queue.
// Reset clears parser state, queue and output register. When the receiver
// stalls, the result holds in the output register, the back end waits in
// its done state, then the queue fills and finally s_tready drops.
// ----------------------------------------------------------------------------
module wav_header_duration_scanner_core #(
	parameter int QUEUE_DEPTH = whds_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] file_byte
	input  logic                          s_tlast,   // final_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] duration_ms, [33:32] status, [34] clipped, [39:35] zero
	output logic [whds_pkg::ODATA_W-1:0]  m_tdata
);

	whds_pkg::q_stat_t q_stat;
	whds_pkg::job_t    push_job;
	whds_pkg::job_t    pop_job;
	logic              push;
	logic              pop;

	whds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	whds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	whds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_job  (pop_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
